### hdl/assert_macros.svh
// Assertion helpers included by text_screen_buffer_writer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

### hdl/tsbw_pkg.sv
package tsbw_pkg;

	localparam int ROW_W      = 6;
	localparam int COL_W      = 8;
	localparam int CHAR_W     = 8;
	localparam int REQ_W      = 3;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_MOVE         = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUT          = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ERASE_LINE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ERASE_SCREEN = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FLUSH        = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ         = 3'd5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_DIRTY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CELL   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NLRET = 2'd2;

	localparam logic [ROW_W-1:0] ROWS_RST  = 6'd25;
	localparam logic [COL_W-1:0] COLS_RST  = 8'd80;
	localparam logic             NLRET_RST = 1'b1;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ROW_W-1:0]  target_row;
		logic [COL_W-1:0]  target_col;
		logic [CHAR_W-1:0] char_code;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [ROW_W-1:0]  report_row;
		logic [COL_W-1:0]  report_col;
		logic [CHAR_W-1:0] cell_char;
		logic              last_of_run;
	} rsp_t;

endpackage

### hdl/tsbw_ram.sv
module tsbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/text_screen_buffer_writer.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (tsbw_pkg::req_t)
// out      output     out_valid / out_ready out_data  (tsbw_pkg::rsp_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset the cell RAM is swept to spaces, in_ready low. Move, CR, backspace, or a
// command with nothing to do is done at accept. Put char: accept, RAM read, compare and
// write, count check. Tab: column mod TAB_STOP, then a read and compare per space on screen
// and a count step per space off it. Erase, line feed: clear cells one at a time. Flush: walk
// the rows in use; read: report the cell. The single RAM port pair and the shared column
// incrementer set these steps; a full result register stalls only a state with a result to load.
`include "assert_macros.svh"

module text_screen_buffer_writer #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128,
	parameter int TAB_STOP = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tsbw_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tsbw_pkg::rsp_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsbw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsbw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W = $clog2(TAB_STOP + 1);
	localparam int ROW_W = tsbw_pkg::ROW_W;
	localparam int COL_W = tsbw_pkg::COL_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_GRD,
		S_GCMP,
		S_ERASE,
		S_FLUSH,
		S_CURS,
		S_RDOUT
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		cell_addr = AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
	endfunction

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	logic [ROW_W-1:0]           rows_q;
	logic [COL_W-1:0]           cols_q;
	logic                       nlret_q;
	logic [ROW_W-1:0]           cur_row_q;
	logic [COL_W-1:0]           cur_col_q;
	logic [MAX_ROWS-1:0]        dirty_q;
	logic [ROW_W-1:0]           wrow_q;
	logic [COL_W-1:0]           wcol_q;
	logic                       lf_q;
	logic                       scr_q;
	logic [ROW_W-1:0]           frow_q;
	logic [COL_W-1:0]           rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [tsbw_pkg::CHAR_W-1:0] glyph_q;
	tsbw_pkg::req_t             req_q;
	logic                       rd_ok_q;
	logic                       out_valid_q;
	tsbw_pkg::rsp_t             out_data_q;

	logic [ROW_W-1:0]           eff_rows;
	logic [COL_W-1:0]           eff_cols;
	logic                       cur_on;
	logic                       in_on;
	logic                       in_acc;
	logic                       out_free;
	logic                       out_load;
	tsbw_pkg::rsp_t             out_next;
	logic [COL_W-1:0]           step_in;
	logic [COL_W:0]             step_nxt;
	logic                       step_end;
	logic [ROW_W-1:0]           wrow_nxt;
	logic [RI_W-1:0]            cur_ridx;
	logic [RI_W-1:0]            wnxt_ridx;
	logic [RI_W-1:0]            f_ridx;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [tsbw_pkg::CHAR_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [tsbw_pkg::CHAR_W-1:0] mem_rdata;

	assign eff_rows = (rows_q > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : rows_q;
	assign eff_cols = ({1'b0, cols_q} > (COL_W + 1)'(MAX_COLS)) ? COL_W'(MAX_COLS) : cols_q;
	assign cur_on   = (cur_row_q < eff_rows) && (cur_col_q < eff_cols);
	assign in_on    = (in_data.target_row < eff_rows) && (in_data.target_col < eff_cols);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// shared column step: cursor advance on a glyph, walk column on erase
	assign step_in  = (state_q == S_ERASE) ? wcol_q : cur_col_q;
	assign step_nxt = {1'b0, step_in} + 1'b1;
	assign step_end = step_nxt >= {1'b0, eff_cols};
	assign wrow_nxt = wrow_q + 1'b1;

	assign cur_ridx  = cur_row_q[RI_W-1:0];
	assign wnxt_ridx = wrow_nxt[RI_W-1:0];
	assign f_ridx    = frow_q[RI_W-1:0];

	always_comb begin
		out_load = 1'b0;
		out_next = '0;
		case (state_q)
			S_FLUSH: begin
				out_load = (frow_q < eff_rows) && dirty_q[f_ridx] && out_free;
				out_next.result_kind = tsbw_pkg::KIND_DIRTY;
				out_next.report_row  = frow_q;
			end
			S_CURS: begin
				out_load = out_free;
				out_next.result_kind = tsbw_pkg::KIND_CURSOR;
				out_next.report_row  = cur_row_q;
				out_next.report_col  = cur_col_q;
				out_next.last_of_run = 1'b1;
			end
			S_RDOUT: begin
				out_load = out_free;
				out_next.result_kind = tsbw_pkg::KIND_CELL;
				out_next.report_row  = req_q.target_row;
				out_next.report_col  = req_q.target_col;
				out_next.cell_char   = rd_ok_q ? mem_rdata : '0;
				out_next.last_of_run = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr(cur_row_q, cur_col_q);
		mem_wdata = tsbw_pkg::CH_SPACE;
		mem_re    = 1'b0;
		mem_raddr = cell_addr(cur_row_q, cur_col_q);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				mem_re    = in_acc && (in_data.req_type == tsbw_pkg::REQ_READ) && in_on;
				mem_raddr = cell_addr(in_data.target_row, in_data.target_col);
			end
			S_GRD: begin
				mem_re = (cnt_q != '0) && cur_on;
			end
			S_GCMP: begin
				// only a changed cell is written
				mem_we    = mem_rdata != glyph_q;
				mem_wdata = glyph_q;
			end
			S_ERASE: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(wrow_q, wcol_q);
			end
			default: ;
		endcase
	end

	tsbw_ram #(
		.WIDTH(tsbw_pkg::CHAR_W),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= tsbw_pkg::ROWS_RST;
			cols_q  <= tsbw_pkg::COLS_RST;
			nlret_q <= tsbw_pkg::NLRET_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tsbw_pkg::CFG_ROWS:  rows_q  <= cfg_data[ROW_W-1:0];
				tsbw_pkg::CFG_COLS:  cols_q  <= cfg_data[COL_W-1:0];
				tsbw_pkg::CFG_NLRET: nlret_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			dirty_q     <= '1;
			wrow_q      <= '0;
			wcol_q      <= '0;
			lf_q        <= 1'b0;
			scr_q       <= 1'b0;
			frow_q      <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			glyph_q     <= '0;
			req_q       <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= out_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						req_q <= in_data;
						case (in_data.req_type)
							tsbw_pkg::REQ_MOVE: begin
								cur_row_q <= in_data.target_row;
								cur_col_q <= in_data.target_col;
							end
							tsbw_pkg::REQ_PUT: begin
								if (cur_on) begin
									case (in_data.char_code)
										tsbw_pkg::CH_TAB: begin
											rem_q   <= cur_col_q;
											glyph_q <= tsbw_pkg::CH_SPACE;
											state_q <= S_MOD;
										end
										tsbw_pkg::CH_CR: begin
											cur_col_q <= '0;
										end
										tsbw_pkg::CH_LF: begin
											wrow_q            <= cur_row_q;
											wcol_q            <= cur_col_q;
											dirty_q[cur_ridx] <= 1'b1;
											lf_q              <= 1'b1;
											scr_q             <= 1'b0;
											state_q           <= S_ERASE;
										end
										tsbw_pkg::CH_BS: begin
											if (cur_col_q != '0) begin
												cur_col_q <= cur_col_q - 1'b1;
											end else if (cur_row_q != '0) begin
												cur_row_q <= cur_row_q - 1'b1;
											end
										end
										default: begin
											glyph_q <= in_data.char_code;
											cnt_q   <= CNT_W'(1);
											state_q <= S_GRD;
										end
									endcase
								end
							end
							tsbw_pkg::REQ_ERASE_LINE, tsbw_pkg::REQ_ERASE_SCREEN: begin
								if (cur_on) begin
									wrow_q            <= cur_row_q;
									wcol_q            <= cur_col_q;
									dirty_q[cur_ridx] <= 1'b1;
									lf_q              <= 1'b0;
									scr_q             <= in_data.req_type ==
										tsbw_pkg::REQ_ERASE_SCREEN;
									state_q           <= S_ERASE;
								end
							end
							tsbw_pkg::REQ_FLUSH: begin
								frow_q  <= '0;
								state_q <= S_FLUSH;
							end
							tsbw_pkg::REQ_READ: begin
								rd_ok_q <= in_on;
								state_q <= S_RDOUT;
							end
							default: ;
						endcase
					end
				end
				// column mod tab stop by repeated subtraction
				S_MOD: begin
					if (rem_q >= COL_W'(TAB_STOP)) begin
						rem_q <= rem_q - COL_W'(TAB_STOP);
					end else begin
						cnt_q   <= CNT_W'(TAB_STOP) - rem_q[CNT_W-1:0];
						state_q <= S_GRD;
					end
				end
				S_GRD: begin
					if (cnt_q == '0) begin
						state_q <= S_IDLE;
					end else if (cur_on) begin
						state_q <= S_GCMP;
					end else begin
						// tab space that fell off screen
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_GCMP: begin
					if (mem_rdata != glyph_q) begin
						dirty_q[cur_ridx] <= 1'b1;
					end
					if (step_end) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= step_nxt[COL_W-1:0];
					end
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_GRD;
				end
				S_ERASE: begin
					if (!step_end) begin
						wcol_q <= step_nxt[COL_W-1:0];
					end else if (scr_q && (wrow_nxt < eff_rows)) begin
						wrow_q             <= wrow_nxt;
						wcol_q             <= '0;
						dirty_q[wnxt_ridx] <= 1'b1;
					end else begin
						if (lf_q) begin
							if (nlret_q) begin
								cur_col_q <= '0;
							end
							cur_row_q <= cur_row_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (frow_q >= eff_rows) begin
						state_q <= S_CURS;
					end else if (!dirty_q[f_ridx]) begin
						frow_q <= frow_q + 1'b1;
					end else if (out_free) begin
						dirty_q[f_ridx] <= 1'b0;
						frow_q          <= frow_q + 1'b1;
					end
				end
				S_CURS, S_RDOUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_glyph_on_screen, clk, arst_n, (state_q == S_GCMP) |-> $past(cur_on), "glyph compare with cursor off screen")
	`ASSERT_CLK(a_glyph_marks_dirty, clk, arst_n, (state_q == S_GCMP && mem_we) |=> dirty_q[$past(cur_ridx)], "changed cell left its row clean")
	`ASSERT_NEVER(a_no_write_idle, clk, arst_n, (state_q == S_IDLE || state_q == S_FLUSH) && mem_we, "cell write outside a writing state")
	`ASSERT_CLK(a_only_dirty_not_last, clk, arst_n, (out_valid_q && !out_data_q.last_of_run) |-> (out_data_q.result_kind == tsbw_pkg::KIND_DIRTY), "non-final result is not a dirty row")

endmodule
